@@ hdl/eor_pkg.sv @@
// ----------------------------------------------------------------------------
// eor_pkg
// Shared constants and the arctangent step table for the elliptical offset
// rotator datapath.
// ----------------------------------------------------------------------------
package eor_pkg;

  // field and register widths fixed by the interface
  localparam int ANGLE_W       = 16;
  localparam int AXIS_RATIO_W  = 17;
  localparam int INV_RATIO_W   = 23;
  localparam int CFG_DATA_W    = 23;
  localparam int CFG_IDX_W     = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AXIS_RATIO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INV_RATIO  = 1'b1;

  // register reset values
  localparam logic [AXIS_RATIO_W-1:0] AXIS_RATIO_RST = 17'd56158;
  localparam logic [INV_RATIO_W-1:0]  INV_RATIO_RST  = 23'd76479;

  // extra fraction bits carried through the rotation
  localparam int GUARD_BITS = 8;

  // angle accumulator, 2^32 units per turn plus headroom
  localparam int ZW = 34;

  // 1/K in Q0.32
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;

  // half an lsb for the 16-bit fraction drops
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517C;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A2F;
      5'd19:   val = 32'h0000_0517;
      5'd20:   val = 32'h0000_028B;
      5'd21:   val = 32'h0000_0145;
      5'd22:   val = 32'h0000_00A2;
      5'd23:   val = 32'h0000_0051;
      5'd24:   val = 32'h0000_0028;
      5'd25:   val = 32'h0000_0014;
      5'd26:   val = 32'h0000_000A;
      5'd27:   val = 32'h0000_0005;
      5'd28:   val = 32'h0000_0002;
      5'd29:   val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/eor_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// eor_cordic_stage
// One registered micro-rotation of the CORDIC pipeline, driven by the sign
// of the residual angle.
// ----------------------------------------------------------------------------
module eor_cordic_stage
  import eor_pkg::*;
#(
  parameter int DW    = 36,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic                 valid_out,
  output logic signed [DW-1:0] x_out,
  output logic signed [DW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic [31:0] ATAN_STEP = atan_entry(5'(STAGE));
  localparam logic signed [ZW-1:0] ATAN_Z = $signed(ZW'(ATAN_STEP));

  logic                 valid_r;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [DW-1:0] dx, dy;

  always_comb begin
    // arithmetic shift floors, as the rotation expects
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    if (!z_in[ZW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ATAN_Z;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign valid_out = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;

endmodule

@@ hdl/elliptical_offset_rotator_core.sv @@
// ----------------------------------------------------------------------------
// elliptical_offset_rotator_core
// Scales the y offset by the axis ratio, rotates (x, y') by minus the turn
// angle with a pipelined CORDIC, then undoes the gain and the y scaling and
// saturates both results.
// ----------------------------------------------------------------------------
// One offset pair is taken on every clock cycle in which start is high and
// busy is low; busy is high only while reset is applied and for the cycle
// right after it. Each beat comes back on out_valid after passing through the
// registers p0 and p1 for the y scaling multiply and the half-turn
// pre-rotation, the register of each CORDIC stage, and g0 to g5 for the gain
// multiply (split into 32-bit partial products), rounding, the inverse-ratio
// multiply and saturation. Results are not held, so the receiver must take
// every strobe. The ratio registers are read by the pipeline on the fly and
// are only to be written while no beat is in flight.
// ----------------------------------------------------------------------------
module elliptical_offset_rotator_core
  import eor_pkg::*;
#(
  parameter int CORDIC_STAGES = 18,
  parameter int OFFSET_WIDTH  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [OFFSET_WIDTH-1:0] in_offset_x,
  input  logic signed [OFFSET_WIDTH-1:0] in_offset_y,
  input  logic signed [ANGLE_W-1:0]      in_turn_angle,
  output logic                           out_valid,
  output logic signed [OFFSET_WIDTH-1:0] out_rotated_x,
  output logic signed [OFFSET_WIDTH-1:0] out_rotated_y,
  output logic                           out_clipped,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int OW = OFFSET_WIDTH;
  localparam int PW = OW + AXIS_RATIO_W;          // |y| * ratio
  localparam int YW = OW + 2;                     // scaled y, signed
  localparam int DW = OW + 12;                    // rotation datapath
  localparam int MW = (DW > 32) ? DW : 33;        // magnitude into gain multiply
  localparam int GW = MW + 1 - GUARD_BITS;        // after guard drop
  localparam int QW = GW + INV_RATIO_W;           // y times inverse ratio
  localparam int SW = QW - 15;                    // after 16-bit round
  localparam int NS = CORDIC_STAGES;
  localparam logic [MW:0] GUARD_HALF = (MW+1)'(1) << (GUARD_BITS - 1);

  // returns {clip, value}
  function automatic logic [OW:0] saturate(input logic neg, input logic [SW-1:0] mag);
    logic [SW-1:0] lim;
    logic [OW-1:0] res;
    logic          clip;
    lim  = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    clip = 1'b0;
    if (neg && (mag != '0)) begin
      if (mag > lim + SW'(1)) begin
        clip = 1'b1;
        res  = {1'b1, {(OW-1){1'b0}}};
      end else begin
        res = '0 - mag[OW-1:0];
      end
    end else begin
      if (mag > lim) begin
        clip = 1'b1;
        res  = lim[OW-1:0];
      end else begin
        res = mag[OW-1:0];
      end
    end
    return {clip, res};
  endfunction

  // configuration
  logic [AXIS_RATIO_W-1:0] axis_ratio_r;
  logic [INV_RATIO_W-1:0]  inv_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_ratio_r <= AXIS_RATIO_RST;
      inv_ratio_r  <= INV_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_AXIS_RATIO: axis_ratio_r <= cfg_wdata[AXIS_RATIO_W-1:0];
        CFG_IDX_INV_RATIO:  inv_ratio_r  <= cfg_wdata[INV_RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r | ~rst_n;
  assign accept = start & ~busy;

  // stage p0: y magnitude times axis ratio
  logic                      p0_vld_r;
  logic signed [OW-1:0]      p0_x_r;
  logic                      p0_yneg_r;
  logic [PW-1:0]             p0_prod_r, p0_prod_nxt;
  logic signed [ANGLE_W-1:0] p0_a_r;
  logic [OW-1:0]             y_mag;

  always_comb begin
    y_mag       = in_offset_y[OW-1] ? ('0 - in_offset_y) : in_offset_y;
    p0_prod_nxt = PW'(y_mag) * PW'(axis_ratio_r);
  end

  // stage p1: round, half-turn pre-rotation, guard bits, angle setup
  logic                 p1_vld_r;
  logic signed [DW-1:0] p1_x_r, p1_x_nxt;
  logic signed [DW-1:0] p1_y_r, p1_y_nxt;
  logic signed [ZW-1:0] p1_z_r, p1_z_nxt;
  logic [PW-1:0]        prod_rnd;
  logic [OW:0]          ym;
  logic                 flip;
  logic signed [YW-1:0] xs, ys;
  logic signed [16:0]   a_adj, a_neg;

  always_comb begin
    prod_rnd = p0_prod_r + PW'(HALF_Q16);
    ym       = prod_rnd[PW-1:16];
    flip     = (p0_a_r > 16'sd16384) || (p0_a_r < -16'sd16384);
    xs       = YW'(p0_x_r);
    if (flip) begin
      xs = -xs;
    end
    ys = (p0_yneg_r ^ flip) ? -$signed(YW'(ym)) : $signed(YW'(ym));
    a_adj = 17'(p0_a_r);
    if (flip) begin
      a_adj = p0_a_r[ANGLE_W-1] ? a_adj + 17'sd32768 : a_adj - 17'sd32768;
    end
    a_neg    = -a_adj;
    p1_x_nxt = {{(DW-YW-GUARD_BITS){xs[YW-1]}}, xs, {GUARD_BITS{1'b0}}};
    p1_y_nxt = {{(DW-YW-GUARD_BITS){ys[YW-1]}}, ys, {GUARD_BITS{1'b0}}};
    p1_z_nxt = {{(ZW-33){a_neg[16]}}, a_neg, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= accept;
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p0_x_r    <= in_offset_x;
    p0_yneg_r <= in_offset_y[OW-1];
    p0_prod_r <= p0_prod_nxt;
    p0_a_r    <= in_turn_angle;
    p1_x_r    <= p1_x_nxt;
    p1_y_r    <= p1_y_nxt;
    p1_z_r    <= p1_z_nxt;
  end

  // cordic pipeline
  logic                 cv [0:NS];
  logic signed [DW-1:0] cx [0:NS];
  logic signed [DW-1:0] cy [0:NS];
  logic signed [ZW-1:0] cz [0:NS-1];

  assign cv[0] = p1_vld_r;
  assign cx[0] = p1_x_r;
  assign cy[0] = p1_y_r;
  assign cz[0] = p1_z_r;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k < NS - 1) begin : g_mid
      eor_cordic_stage #(
        .DW    (DW),
        .STAGE (k)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cv[k]),
        .x_in      (cx[k]),
        .y_in      (cy[k]),
        .z_in      (cz[k]),
        .valid_out (cv[k+1]),
        .x_out     (cx[k+1]),
        .y_out     (cy[k+1]),
        .z_out     (cz[k+1])
      );
    end else begin : g_last
      // residual angle is not needed past the last stage
      eor_cordic_stage #(
        .DW    (DW),
        .STAGE (k)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cv[k]),
        .x_in      (cx[k]),
        .y_in      (cy[k]),
        .z_in      (cz[k]),
        .valid_out (cv[k+1]),
        .x_out     (cx[k+1]),
        .y_out     (cy[k+1]),
        .z_out     ()
      );
    end
  end

  // back end: six stages, valid bits in one shift vector
  logic [5:0] tail_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_vld_r <= '0;
    end else begin
      tail_vld_r <= {tail_vld_r[4:0], cv[NS]};
    end
  end

  // g0: sign and magnitude
  logic          g0_nx_r, g0_ny_r;
  logic [MW-1:0] g0_mx_r, g0_my_r;
  logic [DW-1:0] abs_x, abs_y;

  always_comb begin
    abs_x = cx[NS][DW-1] ? ('0 - cx[NS]) : cx[NS];
    abs_y = cy[NS][DW-1] ? ('0 - cy[NS]) : cy[NS];
  end

  // g1: gain partial products, low and high halves
  logic          g1_nx_r, g1_ny_r;
  logic [63:0]   g1_xlo_r, g1_ylo_r;
  logic [MW-1:0] g1_xhi_r, g1_yhi_r;

  // g2: partial product sum
  logic          g2_nx_r, g2_ny_r;
  logic [MW-1:0] g2_rx_r, g2_ry_r, g2_rx_nxt, g2_ry_nxt;
  logic [63:0]   xlo_rnd, ylo_rnd;

  always_comb begin
    xlo_rnd   = g1_xlo_r + 64'h0000_0000_8000_0000;
    ylo_rnd   = g1_ylo_r + 64'h0000_0000_8000_0000;
    g2_rx_nxt = g1_xhi_r + MW'(xlo_rnd[63:32]);
    g2_ry_nxt = g1_yhi_r + MW'(ylo_rnd[63:32]);
  end

  // g3: drop guard bits
  logic          g3_nx_r, g3_ny_r;
  logic [GW-1:0] g3_gx_r, g3_gy_r;
  logic [MW:0]   gx_rnd, gy_rnd;

  always_comb begin
    gx_rnd = {1'b0, g2_rx_r} + GUARD_HALF;
    gy_rnd = {1'b0, g2_ry_r} + GUARD_HALF;
  end

  // g4: x saturation, y times inverse ratio
  logic          g4_ny_r;
  logic [OW:0]   g4_xsat_r;
  logic [QW-1:0] g4_py_r;

  // g5: y round and saturation, output registers
  logic [QW:0]   py_rnd;
  logic [OW:0]   ysat;
  logic          out_valid_unused;
  logic signed [OW-1:0] out_x_r, out_y_r;
  logic          out_clip_r;

  always_comb begin
    py_rnd = {1'b0, g4_py_r} + (QW+1)'(HALF_Q16);
    ysat   = saturate(g4_ny_r, py_rnd[QW:16]);
  end

  assign out_valid_unused = 1'b0;

  always_ff @(posedge clk) begin
    g0_nx_r   <= cx[NS][DW-1];
    g0_ny_r   <= cy[NS][DW-1];
    g0_mx_r   <= MW'(abs_x);
    g0_my_r   <= MW'(abs_y);

    g1_nx_r   <= g0_nx_r;
    g1_ny_r   <= g0_ny_r;
    g1_xlo_r  <= 64'(g0_mx_r[31:0]) * 64'(INV_GAIN_Q32);
    g1_ylo_r  <= 64'(g0_my_r[31:0]) * 64'(INV_GAIN_Q32);
    g1_xhi_r  <= MW'(g0_mx_r[MW-1:32]) * MW'(INV_GAIN_Q32);
    g1_yhi_r  <= MW'(g0_my_r[MW-1:32]) * MW'(INV_GAIN_Q32);

    g2_nx_r   <= g1_nx_r;
    g2_ny_r   <= g1_ny_r;
    g2_rx_r   <= g2_rx_nxt;
    g2_ry_r   <= g2_ry_nxt;

    g3_nx_r   <= g2_nx_r;
    g3_ny_r   <= g2_ny_r;
    g3_gx_r   <= gx_rnd[MW:GUARD_BITS];
    g3_gy_r   <= gy_rnd[MW:GUARD_BITS];

    g4_ny_r   <= g3_ny_r;
    g4_xsat_r <= saturate(g3_nx_r, SW'(g3_gx_r));
    g4_py_r   <= QW'(g3_gy_r) * QW'(inv_ratio_r);

    out_x_r    <= g4_xsat_r[OW-1:0];
    out_y_r    <= ysat[OW-1:0];
    out_clip_r <= g4_xsat_r[OW] | ysat[OW] | out_valid_unused;
  end

  assign out_valid     = tail_vld_r[5];
  assign out_rotated_x = out_x_r;
  assign out_rotated_y = out_y_r;
  assign out_clipped   = out_clip_r;

endmodule

@@ hdl/eor_checker.sv @@
// ----------------------------------------------------------------------------
// eor_checker
// Port-level checks on the rotator: fixed latency, saturation flag and
// reset behavior. Bound to the top level at the end of this file.
// ----------------------------------------------------------------------------
module eor_checker #(
  parameter int CORDIC_STAGES = 18,
  parameter int OFFSET_WIDTH  = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [OFFSET_WIDTH-1:0] out_rotated_x,
  input logic [OFFSET_WIDTH-1:0] out_rotated_y,
  input logic                    out_clipped
);

  localparam int LATENCY = CORDIC_STAGES + 8;
  localparam logic [OFFSET_WIDTH-1:0] MAX_V = {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
  localparam logic [OFFSET_WIDTH-1:0] MIN_V = {1'b1, {(OFFSET_WIDTH-1){1'b0}}};

  // every result beat goes back to a beat taken a fixed time earlier
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result beat without a matching input beat");

  // a clipped result sits at a rail on at least one axis
  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_rotated_x == MAX_V || out_rotated_x == MIN_V ||
       out_rotated_y == MAX_V || out_rotated_y == MIN_V))
    else $error("clip flag with both results inside range");

  // ready for input once reset was already released in the previous cycle
  a_ready_after_reset: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy outside of reset");

  // reset flushes the pipeline
  a_flush_on_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind elliptical_offset_rotator_core eor_checker #(
  .CORDIC_STAGES (CORDIC_STAGES),
  .OFFSET_WIDTH  (OFFSET_WIDTH)
) u_eor_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_rotated_x (out_rotated_x),
  .out_rotated_y (out_rotated_y),
  .out_clipped   (out_clipped)
);
